FILE: design/ytg_pkg.sv
package ytg_pkg;

  localparam int QY  = 4768;
  localparam int QBU = 8266;
  localparam int QRV = 6537;
  localparam int QGV = 3330;
  localparam int QGU = 1602;

  localparam int LumaOffset   = 16;
  localparam int ChromaOffset = 128;
  localparam int QShift       = 12;

  localparam logic [7:0] BlackThresholdReset = 8'd22;
  localparam logic [6:0] GammaMax            = 7'h7F;

  localparam logic [6:0] GammaRom [0:255] = '{
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1,
    7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1,
    7'd1, 7'd1, 7'd1, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2,
    7'd2, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2,
    7'd3, 7'd3, 7'd3, 7'd3, 7'd3, 7'd3, 7'd3, 7'd3,
    7'd3, 7'd4, 7'd4, 7'd4, 7'd4, 7'd4, 7'd4, 7'd4,
    7'd4, 7'd5, 7'd5, 7'd5, 7'd5, 7'd5, 7'd5, 7'd5,
    7'd6, 7'd6, 7'd6, 7'd6, 7'd6, 7'd6, 7'd7, 7'd7,
    7'd7, 7'd7, 7'd7, 7'd8, 7'd8, 7'd8, 7'd8, 7'd8,
    7'd9, 7'd9, 7'd9, 7'd9, 7'd10, 7'd10, 7'd10, 7'd10,
    7'd10, 7'd11, 7'd11, 7'd11, 7'd11, 7'd12, 7'd12, 7'd12,
    7'd13, 7'd13, 7'd13, 7'd13, 7'd14, 7'd14, 7'd14, 7'd15,
    7'd15, 7'd15, 7'd16, 7'd16, 7'd16, 7'd16, 7'd17, 7'd17,
    7'd18, 7'd18, 7'd18, 7'd19, 7'd19, 7'd19, 7'd20, 7'd20,
    7'd20, 7'd21, 7'd21, 7'd22, 7'd22, 7'd22, 7'd23, 7'd23,
    7'd24, 7'd24, 7'd24, 7'd25, 7'd25, 7'd26, 7'd26, 7'd27,
    7'd27, 7'd28, 7'd28, 7'd29, 7'd29, 7'd29, 7'd30, 7'd30,
    7'd31, 7'd31, 7'd32, 7'd33, 7'd33, 7'd34, 7'd34, 7'd35,
    7'd35, 7'd36, 7'd36, 7'd37, 7'd37, 7'd38, 7'd39, 7'd39,
    7'd40, 7'd40, 7'd41, 7'd42, 7'd42, 7'd43, 7'd43, 7'd44,
    7'd45, 7'd45, 7'd46, 7'd47, 7'd47, 7'd48, 7'd49, 7'd49,
    7'd50, 7'd51, 7'd51, 7'd52, 7'd53, 7'd54, 7'd54, 7'd55,
    7'd56, 7'd56, 7'd57, 7'd58, 7'd59, 7'd60, 7'd60, 7'd61,
    7'd62, 7'd63, 7'd64, 7'd64, 7'd65, 7'd66, 7'd67, 7'd68,
    7'd69, 7'd69, 7'd70, 7'd71, 7'd72, 7'd73, 7'd74, 7'd75,
    7'd76, 7'd76, 7'd77, 7'd78, 7'd79, 7'd80, 7'd81, 7'd82,
    7'd83, 7'd84, 7'd85, 7'd86, 7'd87, 7'd88, 7'd89, 7'd90,
    7'd91, 7'd92, 7'd93, 7'd94, 7'd95, 7'd96, 7'd97, 7'd99,
    7'd100, 7'd101, 7'd102, 7'd103, 7'd104, 7'd105, 7'd106, 7'd107,
    7'd109, 7'd110, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116, 7'd117,
    7'd118, 7'd119, 7'd121, 7'd122, 7'd123, 7'd124, 7'd126, 7'd127
  };

  typedef struct packed {
    logic [6:0] blue;
    logic [6:0] red;
    logic [6:0] green;
  } grb_t;

  function automatic logic [6:0] gamma_curve(logic signed [11:0] v);
    logic [6:0] res;
    if (v[11]) begin
      res = 7'd0;
    end else if (v[10:8] != 3'd0) begin
      res = GammaMax;
    end else begin
      res = GammaRom[v[7:0]];
    end
    return res;
  endfunction

endpackage

FILE: design/ytg_pixel.sv
module ytg_pixel (
  input  logic [7:0]   luma_i,
  input  logic [7:0]   cb_i,
  input  logic [7:0]   cr_i,
  input  logic [7:0]   threshold_i,
  output ytg_pkg::grb_t pix_o
);
  import ytg_pkg::*;

  logic signed [9:0]  y_off;
  logic signed [9:0]  u_off;
  logic signed [9:0]  v_off;
  logic signed [23:0] ly;
  logic signed [23:0] r_sum;
  logic signed [23:0] g_sum;
  logic signed [23:0] b_sum;
  logic signed [11:0] r_q;
  logic signed [11:0] g_q;
  logic signed [11:0] b_q;
  logic signed [11:0] th;
  logic               black;

  function automatic logic signed [11:0] trunc_q12(logic signed [23:0] s);
    logic corr;
    corr = s[23] && (s[QShift-1:0] != '0);
    return $signed(s[23:QShift]) + $signed({11'd0, corr});
  endfunction

  always_comb begin
    y_off = $signed({2'b00, luma_i}) - 10'(LumaOffset);
    u_off = $signed({2'b00, cb_i}) - 10'(ChromaOffset);
    v_off = $signed({2'b00, cr_i}) - 10'(ChromaOffset);
    ly    = 24'(QY * y_off);
    r_sum = ly + 24'(QRV * v_off);
    g_sum = ly - 24'(QGV * v_off) - 24'(QGU * u_off);
    b_sum = ly + 24'(QBU * u_off);
    r_q   = trunc_q12(r_sum);
    g_q   = trunc_q12(g_sum);
    b_q   = trunc_q12(b_sum);
    th    = $signed({4'd0, threshold_i});
    black = (r_q < th) && (g_q < th) && (b_q < th);
    if (black) begin
      pix_o = '0;
    end else begin
      pix_o.green = gamma_curve(g_q);
      pix_o.red   = gamma_curve(r_q);
      pix_o.blue  = gamma_curve(b_q);
    end
  end

endmodule

FILE: design/yuyv_to_gamma_grb.sv
// YUYV to gamma-corrected GRB converter. Each request is one YUYV macropixel
// and yields one result holding two pixels that share its chroma, converted
// with BT.601 studio-range Q12 coefficients, forced black when all channels
// fall below black_threshold (APB offset 0x0, reset 22), then gamma mapped to
// 7 bits. One request is taken every clock while m_axis_tready stays high.
// The request is captured in the input register, converted by combinational
// logic, and its result is captured in the result register, which drives
// m_axis_tvalid and m_axis_tdata. A waiting result holds the pipeline;
// once the input register is also full, s_axis_tready stays low for every
// cycle that m_axis_tready is low.
module yuyv_to_gamma_grb (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // luma_first[7:0], chroma_blue[15:8], luma_second[23:16], chroma_red[31:24]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // green_first[6:0], red_first[13:7], blue_first[20:14],
  // green_second[27:21], red_second[34:28], blue_second[41:35], zero [47:42]
  output logic [47:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ytg_pkg::*;

  logic        in_valid_q;
  logic [31:0] in_data_q;
  logic        out_valid_q;
  logic [47:0] out_data_q;
  logic [7:0]  thresh_q;
  logic        out_ready;
  logic        in_ready;
  logic        reg_sel;
  grb_t        pix_first;
  grb_t        pix_second;

  assign reg_sel   = (paddr[2] == 1'b0);
  assign pready    = 1'b1;
  assign prdata    = reg_sel ? {24'd0, thresh_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= BlackThresholdReset;
    end else if (psel && penable && pwrite && reg_sel) begin
      thresh_q <= pwdata[7:0];
    end
  end

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign in_ready      = !in_valid_q || out_ready;
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
    end
    if (out_ready && in_valid_q) begin
      out_data_q <= {6'd0, pix_second, pix_first};
    end
  end

  ytg_pixel u_pixel_first (
    .luma_i      (in_data_q[7:0]),
    .cb_i        (in_data_q[15:8]),
    .cr_i        (in_data_q[31:24]),
    .threshold_i (thresh_q),
    .pix_o       (pix_first)
  );

  ytg_pixel u_pixel_second (
    .luma_i      (in_data_q[23:16]),
    .cb_i        (in_data_q[15:8]),
    .cr_i        (in_data_q[31:24]),
    .threshold_i (thresh_q),
    .pix_o       (pix_second)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
